// ===== rtl/core/vtx_pkg.sv =====
// shared types, constants and helpers of the vertex transform engine
`default_nettype none

package vtx_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIAG_STEP = 5;
    localparam int N_LANE    = 4;
    localparam int N_ENTRY   = N_LANE * N_LANE;
    localparam int IDX_W     = 4;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int SHIFT_W   = SUM_W - FRAC_BITS;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [WORD_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } op_t;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        op_t                    op;
        logic [IDX_W-1:0]       idx;
        word_t [N_LANE-1:0]     data;
    } item_t;

    // identity matrix: 1.0 on every fifth entry
    function automatic word_t reset_entry(input int i);
        return ((i % DIAG_STEP) == 0) ? ONE_Q16 : '0;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vtx_front.sv =====
// front end: takes input items, classifies them and hands them to the queue
`default_nettype none

module vtx_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire                   kind,
    input  wire [3:0]             entry_index,
    input  wire [31:0]            entry_value,
    input  wire [31:0]            vec_x,
    input  wire [31:0]            vec_y,
    input  wire [31:0]            vec_z,
    input  wire [31:0]            vec_w,
    input  wire                   q_ready,
    output logic                  push,
    output vtx_pkg::item_t        item
);
    import vtx_pkg::*;

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;
    item_t decoded;
    logic  accept;

    always_comb
    begin
        decoded.idx = entry_index;
        if (kind == OP_XFORM)
        begin
            decoded.op   = OP_XFORM;
            decoded.data = {vec_w, vec_z, vec_y, vec_x};
        end
        else
        begin
            // a load carries its value in lane zero
            decoded.op   = OP_LOAD;
            decoded.data = {{(N_LANE-1)*WORD_W{1'b0}}, entry_value};
        end
    end

    assign in_stall = hold_valid_reg && !q_ready;
    assign accept   = in_valid && !in_stall;
    assign push     = hold_valid_reg && q_ready;
    assign item     = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg <= decoded;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vtx_queue.sv =====
// short queue between front and back end
`default_nettype none

module vtx_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  vtx_pkg::item_t        item_in,
    output logic                  ready,
    output logic                  head_valid,
    output vtx_pkg::item_t        head,
    input  wire                   pop
);
    import vtx_pkg::*;

    item_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign ready      = count_reg != QCNT_W'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vtx_back.sv =====
// back end: matrix store, sixteen multipliers, adder tree and saturation
`default_nettype none

module vtx_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          head_valid,
    input  vtx_pkg::item_t               head,
    output logic                         pop,
    output logic                         out_valid,
    input  wire                          out_stall,
    output vtx_pkg::word_t [3:0]         res
);
    import vtx_pkg::*;

    word_t              mat_reg   [N_ENTRY];
    logic signed [PROD_W-1:0] prod_next [N_LANE][N_LANE];
    logic [PROD_W-1:0]  prod_reg  [N_LANE][N_LANE];
    logic [PAIR_W-1:0]  pair_next [N_LANE][2];
    logic [PAIR_W-1:0]  pair_reg  [N_LANE][2];
    logic [SUM_W-1:0]   row_sum   [N_LANE];
    logic [SHIFT_W-1:0] row_shift [N_LANE];
    word_t [N_LANE-1:0] res_next;
    word_t [N_LANE-1:0] res_reg;
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               out_valid_reg;
    logic               s1_ready;
    logic               s2_ready;
    logic               out_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop       = head_valid && s1_ready;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        for (int r = 0; r < N_LANE; r++)
        begin
            for (int c = 0; c < N_LANE; c++)
            begin
                prod_next[r][c] = $signed(mat_reg[r*N_LANE+c]) * $signed(head.data[c]);
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < N_LANE; r++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                pair_next[r][h] = {prod_reg[r][2*h][PROD_W-1], prod_reg[r][2*h]}
                                + {prod_reg[r][2*h+1][PROD_W-1], prod_reg[r][2*h+1]};
            end
        end
    end

    // floor shift back to Q16.16, then clamp to the 32-bit range
    always_comb
    begin
        for (int r = 0; r < N_LANE; r++)
        begin
            row_sum[r]   = {pair_reg[r][0][PAIR_W-1], pair_reg[r][0]}
                         + {pair_reg[r][1][PAIR_W-1], pair_reg[r][1]};
            row_shift[r] = row_sum[r][SUM_W-1:FRAC_BITS];
            if ((&row_shift[r][SHIFT_W-1:WORD_W-1]) || !(|row_shift[r][SHIFT_W-1:WORD_W-1]))
            begin
                res_next[r] = row_shift[r][WORD_W-1:0];
            end
            else if (row_shift[r][SHIFT_W-1])
            begin
                res_next[r] = SAT_MIN;
            end
            else
            begin
                res_next[r] = SAT_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_ENTRY; i++)
            begin
                mat_reg[i] <= reset_entry(i);
            end
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && head.op == OP_LOAD)
            begin
                mat_reg[head.idx] <= head.data[0];
            end
            if (s1_ready)
            begin
                s1_valid_reg <= pop && head.op == OP_XFORM;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            for (int r = 0; r < N_LANE; r++)
            begin
                for (int c = 0; c < N_LANE; c++)
                begin
                    prod_reg[r][c] <= prod_next[r][c];
                end
            end
        end
        if (s2_ready)
        begin
            pair_reg <= pair_next;
        end
        if (out_ready)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vertex_transform_4x4.sv =====
// top level of the vertex transform engine
//
// Multiplies a stored 4x4 signed Q16.16 matrix (identity after reset) by a vector
// (x,y,z,w): each row's four full-width products are summed exactly, shifted right
// by 16 with rounding toward minus infinity and saturated to 32 bits. A load item
// (kind 0) writes one entry, row*4+column, and gives no result; a transform item
// (kind 1) gives one result. One item is taken per clock, loads and transforms alike,
// while in_stall is low, with sixteen multipliers side by side in the back end.
// A transform passes through the input register, the four-entry queue, the multiply
// stage and the pair-add stage, then the final add and saturation into the output
// register. A load affects every transform taken after it.
`default_nettype none

module vertex_transform_4x4 (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         kind,
    input  wire [3:0]   entry_index,
    input  wire [31:0]  entry_value,
    input  wire [31:0]  vec_x,
    input  wire [31:0]  vec_y,
    input  wire [31:0]  vec_z,
    input  wire [31:0]  vec_w,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [31:0] out_w
);
    import vtx_pkg::*;

    logic               push;
    item_t              front_item;
    logic               q_ready;
    logic               head_valid;
    item_t              head;
    logic               pop;
    word_t [N_LANE-1:0] res;

    vtx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .vec_w       (vec_w),
        .q_ready     (q_ready),
        .push        (push),
        .item        (front_item)
    );

    vtx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item_in    (front_item),
        .ready      (q_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    vtx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res        (res)
    );

    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];
    assign out_w = res[3];

endmodule

`default_nettype wire

// ===== rtl/core/vtx_checker.sv =====
// port-level checks of the vertex transform engine and their binding
`default_nettype none

module vtx_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_stall,
    input  wire         out_valid,
    input  wire         out_stall,
    input  wire [31:0]  out_x,
    input  wire [31:0]  out_y,
    input  wire [31:0]  out_z,
    input  wire [31:0]  out_w
);

    // a result waiting on the consumer stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // and its four lanes do not move
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x) && $stable(out_y)
                                   && $stable(out_z) && $stable(out_w))
        else $error("result changed while stalled");

    // reset empties the pipeline and the input register
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("block not empty in reset");

    // the input side can only back up once something has been taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(rst_n))
        else $error("input stall straight out of reset");

endmodule

bind vertex_transform_4x4 vtx_checker u_vtx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench of the vertex transform engine: loads and transforms against a predictor
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vtx_pkg::*;

    typedef word_t [N_LANE-1:0] quad_t;

    typedef struct {
        op_t         op;
        logic [3:0]  idx;
        word_t       val;
        word_t       vx;
        word_t       vy;
        word_t       vz;
        word_t       vw;
        int unsigned gap;
        bit          hold_rx;
        bit          drain_first;
    } vtx_op_t;

    localparam int unsigned N_RANDOM     = 1500;
    localparam int unsigned BURST_LEN    = 60;
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;

    localparam logic signed [49:0] SCALED_MAX = 50'sh7FFF_FFFF;
    localparam logic signed [49:0] SCALED_MIN = -50'sh8000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [3:0]  entry_index = '0;
    logic [31:0] entry_value = '0;
    logic [31:0] vec_x = '0;
    logic [31:0] vec_y = '0;
    logic [31:0] vec_z = '0;
    logic [31:0] vec_w = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_w;

    vtx_op_t     pending_ops[$];
    quad_t       expected_vertices[$];
    word_t       mat_shadow [N_ENTRY];
    vtx_op_t     cur;
    bit          cur_loaded = 1'b0;
    int unsigned gap_left = 0;

    logic        rx_hold_req = 1'b0;
    int unsigned results_due = 0;
    int unsigned results_seen = 0;
    int unsigned rx_wait = 0;
    int unsigned hold_left = 0;
    int unsigned rx_count = 0;
    int unsigned rx_mode = 0;
    int unsigned idle_cycles = 0;
    int unsigned errors = 0;
    string       lane_name [N_LANE] = '{"out_x", "out_y", "out_z", "out_w"};

    vertex_transform_4x4 i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .vec_w       (vec_w),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_w       (out_w)
    );

    always #5 clk = ~clk;

    // rows of the shadow matrix dotted with the vector, floor shift, saturate
    function automatic quad_t transform_vertex(input word_t vx, input word_t vy,
                                               input word_t vz, input word_t vw);
        logic signed [65:0] acc;
        logic signed [63:0] prod;
        logic signed [49:0] scaled;
        word_t              vin [N_LANE];
        quad_t              res;
        vin[0] = vx;
        vin[1] = vy;
        vin[2] = vz;
        vin[3] = vw;
        for (int r = 0; r < N_LANE; r++)
        begin
            acc = '0;
            for (int c = 0; c < N_LANE; c++)
            begin
                prod = $signed(mat_shadow[r * N_LANE + c]) * $signed(vin[c]);
                acc  = acc + prod;
            end
            scaled = 50'(acc >>> FRAC_BITS);
            if (scaled > SCALED_MAX)
                res[r] = SAT_MAX;
            else if (scaled < SCALED_MIN)
                res[r] = SAT_MIN;
            else
                res[r] = scaled[31:0];
        end
        return res;
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 7))
            3: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
            4:
            begin
                case ($urandom_range(0, 4))
                    0: return SAT_MAX;
                    1: return SAT_MIN;
                    2: return '0;
                    3: return ONE_Q16;
                    default: return -ONE_Q16;
                endcase
            end
            5: return $urandom_range(0, 255) - 128;
            6: return $urandom() & 32'hFFFF_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic int unsigned draw_gap(input int unsigned mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    // fields that the operation ignores are filled with noise
    task automatic push_op(input op_t op, input logic [3:0] idx, input word_t val,
                           input word_t vx, input word_t vy, input word_t vz,
                           input word_t vw, input int unsigned gap,
                           input bit hold_rx, input bit drain_first);
        vtx_op_t it;
        it.op          = op;
        it.idx         = (op == OP_LOAD) ? idx : 4'($urandom());
        it.val         = (op == OP_LOAD) ? val : word_t'($urandom());
        it.vx          = (op == OP_XFORM) ? vx : word_t'($urandom());
        it.vy          = (op == OP_XFORM) ? vy : word_t'($urandom());
        it.vz          = (op == OP_XFORM) ? vz : word_t'($urandom());
        it.vw          = (op == OP_XFORM) ? vw : word_t'($urandom());
        it.gap         = gap;
        it.hold_rx     = hold_rx;
        it.drain_first = drain_first;
        pending_ops.push_back(it);
    endtask

    // back-to-back transforms; the receiver holds off early in the burst
    task automatic push_burst();
        for (int k = 0; k < BURST_LEN; k++)
            push_op(OP_XFORM, '0, '0, rand_word(), rand_word(), rand_word(), rand_word(),
                    0, k == 3, 1'b0);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : tx_proc
        bit          drive;
        bit          take_hold;
        int unsigned due;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            rx_hold_req <= 1'b0;
            results_due <= 0;
            for (int i = 0; i < N_ENTRY; i++)
                mat_shadow[i] = (i % DIAG_STEP == 0) ? ONE_Q16 : '0;
        end
        else
        begin
            take_hold = 1'b0;
            due       = results_due;
            drive     = in_valid;
            if (in_valid && !in_stall)
            begin
                if (cur.op == OP_LOAD)
                    mat_shadow[cur.idx] = cur.val;
                else
                begin
                    expected_vertices.push_back(transform_vertex(cur.vx, cur.vy, cur.vz,
                                                                 cur.vw));
                    due++;
                end
                take_hold  = cur.hold_rx;
                cur_loaded = 1'b0;
                drive      = 1'b0;
            end
            if (!drive)
            begin
                if (!cur_loaded && pending_ops.size() != 0)
                begin
                    cur        = pending_ops.pop_front();
                    cur_loaded = 1'b1;
                    gap_left   = cur.gap;
                end
                if (cur_loaded)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    else if (!cur.drain_first || results_seen == due)
                        drive = 1'b1;
                end
            end
            if (drive)
            begin
                kind        <= cur.op;
                entry_index <= cur.idx;
                entry_value <= cur.val;
                vec_x       <= cur.vx;
                vec_y       <= cur.vy;
                vec_z       <= cur.vz;
                vec_w       <= cur.vw;
            end
            in_valid    <= drive;
            rx_hold_req <= take_hold;
            results_due <= due;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : rx_proc
        int unsigned wait_next;
        int unsigned hold_next;
        quad_t       want;
        quad_t       got;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            rx_wait      <= 0;
            hold_left    <= 0;
            results_seen <= 0;
        end
        else
        begin
            wait_next = rx_wait;
            hold_next = hold_left;
            if (out_valid && !out_stall)
            begin
                got = {out_w, out_z, out_y, out_x};
                if (expected_vertices.size() == 0)
                begin
                    $error("result with nothing expected: %h", got);
                    errors++;
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    for (int i = 0; i < N_LANE; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            $error("%s: expected %h, got %h", lane_name[i], want[i], got[i]);
                            errors++;
                        end
                    end
                end
                results_seen <= results_seen + 1;
                rx_count++;
                if (rx_count % 40 == 0)
                    rx_mode = $urandom_range(0, 2);
                wait_next = draw_gap(rx_mode);
            end
            else if (wait_next != 0)
                wait_next--;
            if (hold_next != 0)
                hold_next--;
            if (rx_hold_req)
                hold_next = HOLD_CYCLES;
            rx_wait   <= wait_next;
            hold_left <= hold_next;
            out_stall <= (wait_next != 0) || (hold_next != 0);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[vertex_transform_4x4] ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned seg_mode;
        bit          is_xform;
        seg_mode = 1;

        // identity matrix passes the vector through, floor of -1 raw stays -1
        push_op(OP_XFORM, '0, '0, SAT_MAX, SAT_MIN, 32'hFFFF_FFFF, 32'h0000_0001, 0,
                1'b0, 1'b0);
        // row 0 all max, row 1 all min, row 2 a tiny negative, row 3 only w
        for (int i = 0; i < N_ENTRY; i++)
        begin
            word_t v;
            if (i < 4)
                v = SAT_MAX;
            else if (i < 8)
                v = SAT_MIN;
            else if (i == 8)
                v = 32'hFFFF_FFFF;
            else if (i == 15)
                v = ONE_Q16;
            else
                v = '0;
            push_op(OP_LOAD, 4'(i), v, '0, '0, '0, '0, i % 3, 1'b0, 1'b0);
        end
        push_op(OP_XFORM, '0, '0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 0, 1'b0, 1'b0);
        push_op(OP_XFORM, '0, '0, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1, 1'b0, 1'b0);
        push_op(OP_XFORM, '0, '0, 32'h1, '0, '0, '0, 0, 1'b0, 1'b0);
        push_op(OP_XFORM, '0, '0, '0, '0, '0, '0, 2, 1'b0, 1'b0);
        push_op(OP_LOAD, 4'd15, SAT_MIN, '0, '0, '0, '0, 0, 1'b0, 1'b0);
        push_op(OP_XFORM, '0, '0, '0, '0, '0, SAT_MIN, 0, 1'b0, 1'b0);

        for (int unsigned n = 0; n < N_RANDOM; n++)
        begin
            if (n % 50 == 0)
                seg_mode = $urandom_range(0, 2);
            if (n == 400 || n == 1200)
                push_burst();
            is_xform = $urandom_range(0, 9) < 7;
            push_op(is_xform ? OP_XFORM : OP_LOAD, 4'($urandom()), rand_word(),
                    rand_word(), rand_word(), rand_word(), rand_word(),
                    draw_gap(seg_mode), 1'b0, n % 400 == 200);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // the last item is only done once its valid has dropped
        while (pending_ops.size() != 0 || cur_loaded || in_valid)
            @(posedge clk);
        while (results_seen != results_due)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_vertices.size() == 0)
            $display("[vertex_transform_4x4] OK");
        else
            $display("[vertex_transform_4x4] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
